FILE: hdl/tcpfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Phase and frequency meter package
// Shared widths, codes, reset values and types for the two-channel meter.
// ----------------------------------------------------------------------------
package tcpfm_pkg;

	localparam int STAMP_W    = 16;
	localparam int CLK_W      = 28;
	localparam int PRESC_W    = 16;
	localparam int FREQ_W     = 36;
	localparam int PHASE_W    = 16;
	localparam int COUNT_W    = 17;
	localparam int OVF_W      = 8;
	localparam int CFG_DATA_W = 28;
	localparam int CFG_IDX_W  = 2;

	// Serial divider geometry: 36-bit dividend, 34-bit divisor.
	localparam int DIV_N_W   = 36;
	localparam int DIV_D_W   = 34;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	localparam logic [OVF_W-1:0]   OVF_LIMIT   = OVF_W'(10);
	localparam logic [OVF_W-1:0]   OVF_MAX     = '1;
	localparam logic [15:0]        PHASE_SCALE = 16'd46080;
	localparam logic [PHASE_W-1:0] PHASE_MAX   = '1;
	localparam logic [FREQ_W-1:0]  FREQ_MAX    = '1;

	localparam logic [CLK_W-1:0]   CLK_RESET   = CLK_W'(84000000);
	localparam logic [PRESC_W-1:0] PRESC_RESET = '0;
	localparam logic [STAMP_W-1:0] TOP_RESET   = '1;

	localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESCALER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP = 2'd2;

	typedef enum logic [1:0] {
		REQ_ARM  = 2'd0,
		REQ_REF  = 2'd1,
		REQ_SIG  = 2'd2,
		REQ_TICK = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_MUL  = 3'd1,
		ST_LOAD = 3'd2,
		ST_DIV  = 3'd3,
		ST_FIN  = 3'd4
	} state_t;

endpackage : tcpfm_pkg
`default_nettype wire

FILE: hdl/tcpfm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Capture request channel
// Valid/ready channel that carries one timer event per request.
// ----------------------------------------------------------------------------
interface tcpfm_req_if import tcpfm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [STAMP_W-1:0] capture_value;

	modport source (output valid, output req_type, output capture_value, input ready);
	modport sink   (input valid, input req_type, input capture_value, output ready);
endinterface : tcpfm_req_if
`default_nettype wire

FILE: hdl/tcpfm_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Measurement result channel
// Valid/ready channel that carries one completed measurement per request.
// ----------------------------------------------------------------------------
interface tcpfm_res_if import tcpfm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FREQ_W-1:0]  frequency_q8;
	logic [PHASE_W-1:0] phase_q7;
	logic [COUNT_W-1:0] period_count;
	logic [COUNT_W-1:0] delay_count;
	logic               period_zero;

	modport source (output valid, output frequency_q8, output phase_q7,
		output period_count, output delay_count, output period_zero, input ready);
	modport sink   (input valid, input frequency_q8, input phase_q7,
		input period_count, input delay_count, input period_zero, output ready);
endinterface : tcpfm_res_if
`default_nettype wire

FILE: hdl/tcpfm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; done pulses after the last bit.
// ----------------------------------------------------------------------------
module tcpfm_div import tcpfm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DIV_N_W-1:0] dividend,
	input  wire logic [DIV_D_W-1:0] divisor,
	output logic [DIV_N_W-1:0]      quotient,
	output logic                    done
);

	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_D_W:0]     rem_shift;
	logic [DIV_D_W+1:0]   trial;
	logic                 borrow;

	always_comb begin
		rem_shift = {rem_q, quo_q[DIV_N_W-1]};
		trial     = {1'b0, rem_shift} - {2'b00, dsr_q};
		borrow    = trial[DIV_D_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_N_W-2:0], ~borrow};
			rem_q <= borrow ? rem_shift[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule : tcpfm_div
`default_nettype wire

FILE: hdl/two_channel_phase_frequency_meter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Arm, overflow tick and edge requests that do not complete a measurement are handled in idle.
// An edge that completes a measurement is followed by a multiply, a divider load, 36 steps in
// the bit-serial dividers and then the result hand-off before the next request is taken.
// The result sits in its own output register, so a new request is taken while it waits.
// Reset (arst_n low) clears the control state, but not the datapath registers, and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Two-channel phase and frequency meter
// Pairs reference and signal capture stamps, then derives frequency and phase.
// ----------------------------------------------------------------------------
module two_channel_phase_frequency_meter_unit import tcpfm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	tcpfm_req_if.sink                  capture,
	tcpfm_res_if.source                result
);

	// Wrap-aware difference of two stamps against a modulus of top plus one. A stamp that
	// lies beyond the modulus can make the correction negative; it is clamped to zero.
	function automatic logic [COUNT_W-1:0] wrap_diff(
		input logic [STAMP_W-1:0] newer,
		input logic [STAMP_W-1:0] older,
		input logic [STAMP_W-1:0] top
	);
		logic [COUNT_W-1:0] modulus;
		logic [COUNT_W-1:0] gap;
		modulus = {1'b0, top} + COUNT_W'(1);
		gap     = {1'b0, older} - {1'b0, newer};
		if (newer >= older)
			return {1'b0, newer} - {1'b0, older};
		else if (gap > modulus)
			return '0;
		else
			return modulus - gap;
	endfunction

	// Configuration registers.
	logic [CLK_W-1:0]   timer_clock_q;
	logic [PRESC_W-1:0] prescaler_q;
	logic [STAMP_W-1:0] top_q;

	// Measurement state.
	state_t             state_q, state_n;
	logic               armed_q;
	logic               have_ref_q;
	logic               have_sig_q;
	logic [STAMP_W-1:0] ref_stamp_q;
	logic [STAMP_W-1:0] sig_stamp_q;
	logic [STAMP_W-1:0] prev_stamp_q;
	logic [OVF_W-1:0]   ovf_q;

	// Working registers of one measurement.
	logic [COUNT_W-1:0] period_q;
	logic [COUNT_W-1:0] delay_q;
	logic               zero_q;
	logic [DIV_D_W-1:0] freq_den_q;
	logic [32:0]        phase_num_q;

	// Output register.
	logic               out_valid_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [PHASE_W-1:0] phase_q;
	logic [COUNT_W-1:0] period_out_q;
	logic [COUNT_W-1:0] delay_out_q;
	logic               zero_out_q;

	// Request decode and pairing logic.
	req_type_t          req;
	logic               accept;
	logic               ev_ref;
	logic               ev_sig;
	logic               complete;
	logic [STAMP_W-1:0] ref_new;
	logic [STAMP_W-1:0] sig_new;
	logic [COUNT_W-1:0] period_n;
	logic [COUNT_W-1:0] delay_n;
	logic [OVF_W-1:0]   ovf_inc;

	// Control from the sequencer.
	logic               div_start;
	logic               out_load;

	// Divider results.
	logic [DIV_N_W-1:0] freq_quo;
	logic [DIV_N_W-1:0] phase_quo;
	logic               freq_done;
	logic               phase_done;
	logic [PHASE_W-1:0] phase_sat;

	assign req    = req_type_t'(capture.req_type);
	assign accept = capture.valid && capture.ready;

	always_comb begin
		ev_ref   = accept && armed_q && (req == REQ_REF);
		ev_sig   = accept && armed_q && (req == REQ_SIG);
		complete = (ev_ref || ev_sig) && (have_ref_q || ev_ref) && (have_sig_q || ev_sig);
		ref_new  = ev_ref ? capture.capture_value : ref_stamp_q;
		sig_new  = ev_sig ? capture.capture_value : sig_stamp_q;
		period_n = wrap_diff(ref_new, prev_stamp_q, top_q);
		delay_n  = wrap_diff(sig_new, ref_new, top_q);
		ovf_inc  = (ovf_q == OVF_MAX) ? ovf_q : ovf_q + OVF_W'(1);
	end

	// Sequencer: plain requests are handled in idle; a completed pair walks through
	// multiply, divider load, division and the hand-off to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n       = state_q;
		div_start     = 1'b0;
		out_load      = 1'b0;
		capture.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				capture.ready = 1'b1;
				if (complete)
					state_n = ST_MUL;
			end
			ST_MUL: begin
				state_n = ST_LOAD;
			end
			ST_LOAD: begin
				div_start = 1'b1;
				state_n   = ST_DIV;
			end
			ST_DIV: begin
				if (freq_done)
					state_n = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Configuration writes; an index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_clock_q <= CLK_RESET;
			prescaler_q   <= PRESC_RESET;
			top_q         <= TOP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TIMER_CLOCK: timer_clock_q <= wr_data[CLK_W-1:0];
				REG_PRESCALER:   prescaler_q   <= wr_data[PRESC_W-1:0];
				REG_COUNTER_TOP: top_q         <= wr_data[STAMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Arm, tick and edge handling. Overflow ticks count whether armed or not, and more
	// than ten of them disarm. Edges are only kept while armed. The pairing flags and the
	// previous reference stamp survive arm and disarm.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			have_ref_q   <= 1'b0;
			have_sig_q   <= 1'b0;
			ref_stamp_q  <= '0;
			sig_stamp_q  <= '0;
			prev_stamp_q <= '0;
			ovf_q        <= '0;
		end else if (accept) begin
			unique case (req)
				REQ_ARM: begin
					armed_q <= 1'b1;
					ovf_q   <= '0;
				end
				REQ_TICK: begin
					ovf_q <= ovf_inc;
					if (ovf_inc > OVF_LIMIT)
						armed_q <= 1'b0;
				end
				REQ_REF, REQ_SIG: begin
					if (ev_ref)
						ref_stamp_q <= capture.capture_value;
					if (ev_sig)
						sig_stamp_q <= capture.capture_value;
					if (complete) begin
						have_ref_q   <= 1'b0;
						have_sig_q   <= 1'b0;
						prev_stamp_q <= ref_new;
						armed_q      <= 1'b0;
					end else begin
						have_ref_q <= have_ref_q || ev_ref;
						have_sig_q <= have_sig_q || ev_sig;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Period and delay are captured with the completing edge; the products that feed
	// the dividers are formed in the cycle after, in the multiply state.
	always_ff @(posedge clk) begin
		if (complete) begin
			period_q <= period_n;
			delay_q  <= delay_n;
			zero_q   <= (period_n == '0);
		end
		if (state_q == ST_MUL) begin
			freq_den_q  <= DIV_D_W'((COUNT_W'(prescaler_q) + COUNT_W'(1)))
				* DIV_D_W'(period_q);
			phase_num_q <= 33'(delay_q) * 33'(PHASE_SCALE);
		end
	end

	// Frequency: timer clock in Q.8 divided by (prescaler + 1) * period.
	tcpfm_div u_freq_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({timer_clock_q, 8'h00}),
		.divisor  (freq_den_q),
		.quotient (freq_quo),
		.done     (freq_done)
	);

	// Phase: delay * 46080 / period, which is degrees in 1/128 steps.
	tcpfm_div u_phase_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIV_N_W'(phase_num_q)),
		.divisor  (DIV_D_W'(period_q)),
		.quotient (phase_quo),
		.done     (phase_done)
	);

	assign phase_sat = (phase_quo[DIV_N_W-1:PHASE_W] != '0) ? PHASE_MAX
		: phase_quo[PHASE_W-1:0];

	// Output register. A zero period saturates both quotients and raises the flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			freq_q       <= zero_q ? FREQ_MAX : freq_quo;
			phase_q      <= zero_q ? PHASE_MAX : phase_sat;
			period_out_q <= period_q;
			delay_out_q  <= delay_q;
			zero_out_q   <= zero_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frequency_q8 = freq_q;
	assign result.phase_q7     = phase_q;
	assign result.period_count = period_out_q;
	assign result.delay_count  = delay_out_q;
	assign result.period_zero  = zero_out_q;

	// Both dividers start together and run the same number of steps.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		freq_done == phase_done)
		else $error("dividers out of step");

	// The dividers only finish while the sequencer waits on them.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		freq_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	// A completing edge moves the sequencer on and leaves the block disarmed.
	a_complete_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		complete |=> (state_q == ST_MUL) && !armed_q)
		else $error("completed measurement did not disarm");

	// Too many overflows and armed never coexist.
	a_ovf_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		(ovf_q > OVF_LIMIT) |-> !armed_q)
		else $error("armed after overflow limit");

	// A zero period always reports saturated quotients.
	a_zero_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && zero_out_q) |-> (freq_q == FREQ_MAX) && (phase_q == PHASE_MAX))
		else $error("zero period result not saturated");

endmodule : two_channel_phase_frequency_meter_unit
`default_nettype wire
